### hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial-division prime tester: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int unsigned VALUE_BITS_DEF = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} tdpt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture candidate, divisor back to two
		logic div_start;  // start one remainder pass
		logic next_d;     // move to the next divisor
		logic set_res;    // write the verdict
		logic res_val;    // verdict written by set_res
		logic load_out;   // move verdict to the output register
	} tdpt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lt_two;     // value is zero or one
		logic sq_gt_v;    // divisor squared exceeds value
		logic rem_done;   // remainder pass finished
		logic rem_zero;   // divisor divides value exactly
	} tdpt_stat_t;

endpackage

### hw/rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// values below 4 need no remainder pass; else one pass per divisor tried,
// up to floor(sqrt(candidate)) - 1 divisors (about 46K at 31 bits)
// the per-divisor cost is set by the bit-serial remainder unit
// one request at a time; the next is taken while a result waits at the output
// reset (arst_n low, asynchronous) empties the output and returns to idle
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Tests one unsigned value for primality by trial division with divisors
// from two up to the integer square root.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
	parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  prime_flag
);
	import tdpt_pkg::*;

	tdpt_cmd_t  cmd;
	tdpt_stat_t stat;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdpt_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.candidate (candidate),
		.stat      (stat),
		.prime_flag(prime_flag)
	);

endmodule

### hw/rtl/tdpt_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_rem
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Only the remainder is kept.
// ----------------------------------------------------------------------------
module tdpt_rem #(
	parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] rem
);
	import tdpt_pkg::*;

	localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;

	// shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, dividend[cnt_q]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_TOP;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[VALUE_BITS-1:0];
			end else begin
				rem_q <= trial[VALUE_BITS-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### hw/rtl/tdpt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_dp
// Datapath: candidate, divisor and running square registers, the remainder
// unit, the verdict and the output register.
// ----------------------------------------------------------------------------
module tdpt_dp #(
	parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdpt_pkg::tdpt_cmd_t   cmd,
	input  logic [VALUE_BITS-1:0] candidate,
	output tdpt_pkg::tdpt_stat_t  stat,
	output logic                  prime_flag
);
	import tdpt_pkg::*;

	localparam logic [VALUE_BITS-1:0] D_INIT  = VALUE_BITS'(2);
	localparam logic [VALUE_BITS:0]   SQ_INIT = (VALUE_BITS + 1)'(4);

	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS:0]   sq_q;   // always d_q squared
	logic                  res_q;
	logic                  out_q;
	logic                  rem_done;
	logic [VALUE_BITS-1:0] rem;

	tdpt_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(v_q),
		.divisor (d_q),
		.done    (rem_done),
		.rem     (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q  <= candidate;
			d_q  <= D_INIT;
			sq_q <= SQ_INIT;
		end else if (cmd.next_d) begin
			// (d+1)^2 = d^2 + 2d + 1
			d_q  <= d_q + 1'b1;
			sq_q <= sq_q + {d_q, 1'b0} + 1'b1;
		end
		if (cmd.set_res) begin
			res_q <= cmd.res_val;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign stat.lt_two   = (v_q[VALUE_BITS-1:1] == '0);
	assign stat.sq_gt_v  = (sq_q > {1'b0, v_q});
	assign stat.rem_done = rem_done;
	assign stat.rem_zero = (rem == '0);
	assign prime_flag    = out_q;

endmodule

### hw/rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: steps through bound check, remainder pass and divisor update,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tdpt_pkg::tdpt_stat_t stat,
	output tdpt_pkg::tdpt_cmd_t  cmd
);
	import tdpt_pkg::*;

	tdpt_state_t state_q;
	tdpt_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.lt_two) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b0;
					state_d     = ST_DONE;
				end else if (stat.sq_gt_v) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.rem_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.rem_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b0;
					state_d     = ST_DONE;
				end else begin
					cmd.next_d = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_DONE: begin
				// wait for room in the output register
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/tdpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks of the prime tester, bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker #(
	parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [VALUE_BITS-1:0] candidate,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  prime_flag
);
	import tdpt_pkg::*;

	// output empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_flag))
		else $error("stalled result changed");

	// only one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// a new result appears only at the end of work on a request
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in progress");

	// taking a value below two must not bring up a fresh result flagged prime
	a_small_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (candidate[VALUE_BITS-1:1] == '0) |=> !out_valid
			|| !prime_flag || $past(out_valid))
		else $error("zero or one flagged prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_tdpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.candidate (candidate),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.prime_flag(prime_flag)
);
